@@ src/pfsa_pkg.sv @@
`timescale 1ns / 1ps
package pfsa_pkg;

  localparam int StackDepth  = 4096;
  localparam int StackAw     = 12;
  localparam int CountW      = 13;
  localparam int UnsafeSlots = 16;
  localparam int UnsafeAw    = 4;
  localparam int UcountW     = 5;
  localparam int PfnW        = 52;

  localparam logic [63:0] PgMask   = 64'h0000_0000_0000_0FFF;
  localparam logic [63:0] LastPage = 64'hFFFF_FFFF_FFFF_F000;
  localparam logic [63:0] LowLimit = 64'h0000_0000_0010_0000;
  localparam logic [31:0] TypeUsable = 32'd1;

  typedef enum logic [2:0] {
    CMD_UNSAFE = 3'd0,
    CMD_MAP    = 3'd1,
    CMD_ALLOC  = 3'd2,
    CMD_FREE   = 3'd3,
    CMD_LOWEST = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_UFULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_RD,
    S_WALK_SCAN,
    S_WALK_CHECK,
    S_WALK_PLACE,
    S_LOW_RD,
    S_LOW_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic unsafe_load;
    logic map_start;
    logic pop_read;
    logic pop_finish;
    logic push_free;
    logic scan_reset;
    logic scan_step;
    logic page_place;
    logic low_start;
    logic low_step;
    logic low_finish;
    logic shift_read;
    logic shift_write;
    logic shift_finish;
    logic result_load;
  } ctrl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic stack_empty;
    logic stack_full;
    logic low_claim;
    logic usable;
    logic walk_more;
    logic scan_last;
    logic scan_moved;
    logic scan_abort;
    logic low_last;
    logic shift_last;
  } stat_t;

endpackage

@@ src/page_frame_stack_allocator_core.sv @@
`timescale 1ns / 1ps
// Free-page stack allocator for 4 KiB physical pages.
// Input channel: in_valid/in_stall carry one command beat (cmd, first_value,
// second_value, entry_type). Output channel: out_valid/out_stall carry one
// result beat per command (page_address, status, free_pages, low_page,
// highest_address).
// One command is handled at a time; the next beat is taken the cycle after
// the result beat leaves. Free, unsafe load, unusable map entries and
// commands on an empty stack go straight from dispatch to the result.
// Allocate passes through a stack read state first.
// A usable map entry checks each page against every loaded unsafe range,
// and scans again after a page is moved past a range.
// Take lowest searches the whole stack for the lowest entry, then moves
// each entry above it down by one place.
// The stack is a single-port-write memory with a registered read.
// Reset clears the counts, low page and highest address; no clearing pass.
// While the result beat is stalled it holds and no new command is taken.
module page_frame_stack_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_first_value,
  input  logic [63:0] in_second_value,
  input  logic [31:0] in_entry_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_page_address,
  output logic [1:0]  out_status,
  output logic [12:0] out_free_pages,
  output logic [19:0] out_low_page,
  output logic [63:0] out_highest_address
);
  import pfsa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer.
  pfsa_controller u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctrl(ctrl)
  );

  // Stack, unsafe table and result registers.
  pfsa_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
    .in_cmd(in_cmd), .in_first_value(in_first_value),
    .in_second_value(in_second_value), .in_entry_type(in_entry_type),
    .res_page(out_page_address), .res_status(out_status),
    .res_free(out_free_pages), .res_low(out_low_page),
    .res_top(out_highest_address)
  );

endmodule

@@ src/pfsa_datapath.sv @@
`timescale 1ns / 1ps
module pfsa_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  pfsa_pkg::ctrl_t  ctrl,
  output pfsa_pkg::stat_t  stat,
  input  logic [2:0]       in_cmd,
  input  logic [63:0]      in_first_value,
  input  logic [63:0]      in_second_value,
  input  logic [31:0]      in_entry_type,
  output logic [63:0]      res_page,
  output logic [1:0]       res_status,
  output logic [12:0]      res_free,
  output logic [19:0]      res_low,
  output logic [63:0]      res_top
);
  import pfsa_pkg::*;

  logic [PfnW-1:0]   stack_mem [StackDepth];
  logic [PfnW-1:0]   rd_data_r;
  logic [63:0]       ustart_mem [UnsafeSlots];
  logic [63:0]       uend_mem [UnsafeSlots];

  logic [2:0]        cmd_r;
  logic [63:0]       a_r, b_r;
  logic [31:0]       type_r;
  logic [CountW-1:0] count_r;
  logic [UcountW-1:0] ucount_r;
  logic [19:0]       low_r;
  logic [63:0]       top_r;
  logic [63:0]       pg_r, stop_r;
  logic [UnsafeAw-1:0] k_r;
  logic              moved_r, abort_r;
  logic [1:0]        st_r;
  logic [63:0]       page_r;
  logic [CountW-1:0] idx_r;
  logic [CountW-1:0] best_idx_r;
  logic [PfnW-1:0]   best_r;

  logic [63:0]       stop_w, us, ue, page_base;
  logic              hit, hit_ok;
  logic              low_take;
  logic [PfnW-1:0]   low_best;
  logic [CountW-1:0] low_idx;
  logic [StackAw-1:0] rd_addr;
  logic              rd_en;

  assign stop_w = a_r + b_r;
  assign us = ustart_mem[k_r];
  assign ue = uend_mem[k_r];
  assign hit = (pg_r >= us) && (pg_r < ue);
  assign hit_ok = hit && ({1'b0, k_r} < ucount_r);
  assign page_base = {rd_data_r, 12'h000};

  // Running minimum including the entry on the read port this cycle.
  assign low_take = (idx_r == '0) || (rd_data_r < best_r);
  assign low_best = low_take ? rd_data_r : best_r;
  assign low_idx  = low_take ? idx_r : best_idx_r;

  // Status towards the controller.
  always_comb begin
    stat.cmd         = cmd_t'(cmd_r);
    stat.stack_empty = (count_r == '0);
    stat.stack_full  = (count_r == CountW'(StackDepth));
    stat.low_claim   = (low_r == '0) && (pg_r < LowLimit);
    stat.usable      = (type_r == TypeUsable);
    stat.walk_more   = (pg_r < stop_r);
    stat.scan_last   = ({1'b0, k_r} + UcountW'(1) >= ucount_r);
    stat.scan_moved  = moved_r | (hit_ok && ue <= LastPage);
    stat.scan_abort  = abort_r | (hit_ok && ue > LastPage);
    stat.low_last    = (idx_r + CountW'(1) >= count_r);
    stat.shift_last  = (idx_r + CountW'(1) >= count_r);
  end

  // Stack read port address.
  always_comb begin
    rd_en   = ctrl.pop_read | ctrl.low_start | ctrl.low_step | ctrl.shift_read;
    rd_addr = idx_r[StackAw-1:0];
    if (ctrl.pop_read) begin
      rd_addr = StackAw'(count_r - CountW'(1));
    end else if (ctrl.low_start) begin
      rd_addr = '0;
    end else if (ctrl.shift_read) begin
      rd_addr = StackAw'(idx_r + CountW'(1));
    end else if (ctrl.low_step) begin
      rd_addr = StackAw'(idx_r + CountW'(1));
    end
  end

  // Stack memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
    if (ctrl.push_free && count_r != CountW'(StackDepth)) begin
      stack_mem[count_r[StackAw-1:0]] <= a_r[63:12];
    end else if (ctrl.page_place && !(low_r == '0 && pg_r < LowLimit)
                 && count_r != CountW'(StackDepth)) begin
      stack_mem[count_r[StackAw-1:0]] <= pg_r[63:12];
    end else if (ctrl.shift_write) begin
      stack_mem[idx_r[StackAw-1:0]] <= rd_data_r;
    end
  end

  // Unsafe range table.
  always_ff @(posedge clk) begin
    if (ctrl.unsafe_load && ucount_r != UcountW'(UnsafeSlots)) begin
      ustart_mem[ucount_r[UnsafeAw-1:0]] <= a_r;
      uend_mem[ucount_r[UnsafeAw-1:0]]   <= b_r;
    end
  end

  // Item capture and working registers.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r  <= in_cmd;
      a_r    <= in_first_value;
      b_r    <= in_second_value;
      type_r <= in_entry_type;
      st_r   <= ST_OK;
      page_r <= '0;
    end
    if (ctrl.unsafe_load && ucount_r == UcountW'(UnsafeSlots)) begin
      st_r <= ST_UFULL;
    end
    if (ctrl.map_start) begin
      pg_r   <= (a_r + PgMask) & ~PgMask;
      stop_r <= stop_w & ~PgMask;
    end
    if (ctrl.scan_reset) begin
      k_r     <= '0;
      moved_r <= 1'b0;
      abort_r <= 1'b0;
    end else if (ctrl.scan_step) begin
      if (hit_ok) begin
        if (ue > LastPage) begin
          abort_r <= 1'b1;
        end else begin
          pg_r    <= (ue + PgMask) & ~PgMask;
          moved_r <= 1'b1;
        end
      end
      k_r <= k_r + UnsafeAw'(1);
    end
    if (ctrl.page_place) begin
      if (!(low_r == '0 && pg_r < LowLimit) && count_r == CountW'(StackDepth)) begin
        st_r <= ST_FULL;
      end
      pg_r <= pg_r + 64'd4096;
    end
    if (ctrl.push_free && count_r == CountW'(StackDepth)) begin
      st_r <= ST_FULL;
    end
    if (ctrl.pop_finish) begin
      page_r <= page_base;
    end
    if ((cmd_r == CMD_ALLOC || cmd_r == CMD_LOWEST) && ctrl.capture == 1'b0
        && ctrl.result_load && count_r == '0 && page_r == '0 && st_r == ST_OK
        && !ctrl.pop_finish) begin
      st_r <= ST_EMPTY;
    end
    if (ctrl.low_start) begin
      idx_r      <= '0;
      best_idx_r <= '0;
    end else if (ctrl.low_step) begin
      if (low_take) begin
        best_r     <= rd_data_r;
        best_idx_r <= idx_r;
      end
      if (ctrl.low_finish) begin
        page_r <= {low_best, 12'h000};
        idx_r  <= low_idx;
      end else begin
        idx_r <= idx_r + CountW'(1);
      end
    end
    if (ctrl.shift_write) begin
      idx_r <= idx_r + CountW'(1);
    end
  end

  // Control-visible state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ucount_r <= '0;
      low_r    <= '0;
      top_r    <= '0;
    end else begin
      if (ctrl.unsafe_load && ucount_r != UcountW'(UnsafeSlots)) begin
        ucount_r <= ucount_r + UcountW'(1);
      end
      if (ctrl.map_start && stop_w > top_r) begin
        top_r <= stop_w;
      end
      if (ctrl.page_place) begin
        if (low_r == '0 && pg_r < LowLimit) begin
          low_r <= pg_r[19:0];
        end else if (count_r != CountW'(StackDepth)) begin
          count_r <= count_r + CountW'(1);
        end
      end
      if (ctrl.push_free && count_r != CountW'(StackDepth)) begin
        count_r <= count_r + CountW'(1);
      end
      if (ctrl.pop_finish || ctrl.shift_finish) begin
        count_r <= count_r - CountW'(1);
      end
    end
  end

  // Result beat contents.
  always_comb begin
    res_page   = page_r;
    res_status = st_r;
    res_free   = count_r;
    res_low    = low_r;
    res_top    = top_r;
  end

endmodule

@@ src/pfsa_controller.sv @@
`timescale 1ns / 1ps
module pfsa_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  pfsa_pkg::stat_t  stat,
  output pfsa_pkg::ctrl_t  ctrl
);
  import pfsa_pkg::*;

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_MAP:    state_nxt = stat.usable ? S_WALK_SCAN : S_DONE;
          CMD_ALLOC:  state_nxt = stat.stack_empty ? S_DONE : S_POP_RD;
          CMD_LOWEST: state_nxt = stat.stack_empty ? S_DONE : S_LOW_RD;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_POP_RD:     state_nxt = S_DONE;
      S_WALK_SCAN: begin
        if (!stat.walk_more) state_nxt = S_DONE;
        else state_nxt = S_WALK_CHECK;
      end
      S_WALK_CHECK: begin
        if (stat.scan_abort) state_nxt = S_DONE;
        else if (stat.scan_last) begin
          if (stat.scan_moved) state_nxt = S_WALK_SCAN;
          else state_nxt = S_WALK_PLACE;
        end
      end
      S_WALK_PLACE: begin
        if (!stat.walk_more) state_nxt = S_DONE;
        else if (stat.stack_full && !stat.low_claim) state_nxt = S_DONE;
        else state_nxt = S_WALK_SCAN;
      end
      S_LOW_RD:     state_nxt = S_LOW_SCAN;
      S_LOW_SCAN:   state_nxt = stat.low_last ? S_SHIFT_RD : S_LOW_SCAN;
      S_SHIFT_RD:   state_nxt = stat.shift_last ? S_DONE : S_SHIFT_WR;
      S_SHIFT_WR:   state_nxt = S_SHIFT_RD;
      S_DONE:       if (!out_stall) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Outputs.
  always_comb begin
    ctrl      = '0;
    in_stall  = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    unique case (state_r)
      S_IDLE: ctrl.capture = in_valid;
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_UNSAFE: ctrl.unsafe_load = 1'b1;
          CMD_MAP:    ctrl.map_start = 1'b1;
          CMD_ALLOC:  ctrl.pop_read = !stat.stack_empty;
          CMD_FREE:   ctrl.push_free = 1'b1;
          CMD_LOWEST: ctrl.low_start = !stat.stack_empty;
          default:    ctrl.result_load = 1'b0;
        endcase
        ctrl.result_load = stat.stack_empty;
      end
      S_POP_RD:     ctrl.pop_finish = 1'b1;
      S_WALK_SCAN:  ctrl.scan_reset = 1'b1;
      S_WALK_CHECK: ctrl.scan_step = !stat.scan_abort;
      S_WALK_PLACE: ctrl.page_place = stat.walk_more;
      S_LOW_RD:     ctrl.low_step = 1'b0;
      S_LOW_SCAN: begin
        ctrl.low_step   = 1'b1;
        ctrl.low_finish = stat.low_last;
      end
      S_SHIFT_RD: begin
        ctrl.shift_read   = !stat.shift_last;
        ctrl.shift_finish = stat.shift_last;
      end
      S_SHIFT_WR:   ctrl.shift_write = 1'b1;
      S_DONE:       ctrl.result_load = 1'b0;
      default:      ctrl.result_load = 1'b0;
    endcase
  end

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.pop_finish, ctrl.push_free, ctrl.page_place}))
    else $error("conflicting stack updates");
`endif

endmodule

@@ sim/page_frame_stack_allocator_core_test.sv @@
`timescale 1ns / 1ps
module page_frame_stack_allocator_core_test;
  import pfsa_pkg::*;

  // Command codes that the block must treat as no operation.
  localparam logic [2:0] CmdSpare5 = 3'd5;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  localparam logic [63:0] PageBytes = 64'd4096;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int CycleLimit = 2000000;

  typedef struct {
    logic [63:0] page;
    logic [1:0]  st;
    logic [12:0] free_cnt;
    logic [19:0] low;
    logic [63:0] high;
  } beat_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] a;
    logic [63:0] b;
    logic [31:0] typ;
    bit          typed;
    beat_t       want;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic [63:0] in_first_value = '0;
  logic [63:0] in_second_value = '0;
  logic [31:0] in_entry_type = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_page_address;
  logic [1:0]  out_status;
  logic [12:0] out_free_pages;
  logic [19:0] out_low_page;
  logic [63:0] out_highest_address;

  // Shadow copy of the allocator state.
  logic [PfnW-1:0] pfn_stack [StackDepth];
  int              pfn_count;
  logic [63:0]     hole_start [UnsafeSlots];
  logic [63:0]     hole_end [UnsafeSlots];
  int              hole_count;
  logic [19:0]     held_low;
  logic [63:0]     top_addr;

  beat_t due_q[$];
  stim_t plan_q[$];
  int    errors = 0;
  int    cycles = 0;
  bit    idle_on = 1'b1;

  page_frame_stack_allocator_core i_dut (.*);

  always #5 clk = ~clk;

  // Move a page past every unsafe range covering it; 0 when the walk must end.
  function automatic bit skip_holes(inout logic [63:0] pg);
    bit moved;
    moved = 1'b1;
    while (moved) begin
      moved = 1'b0;
      for (int k = 0; k < hole_count; k++) begin
        if (pg >= hole_start[k] && pg < hole_end[k]) begin
          if (hole_end[k] > LastPage) return 1'b0;
          pg = (hole_end[k] + PgMask) & ~PgMask;
          moved = 1'b1;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic status_t walk_entry(logic [63:0] base, logic [63:0] len,
                                         logic [31:0] typ);
    logic [63:0] stop;
    logic [63:0] pg;
    stop = base + len;
    if (stop > top_addr) top_addr = stop;
    if (typ != TypeUsable) return ST_OK;
    pg = (base + PgMask) & ~PgMask;
    stop = stop & ~PgMask;
    while (pg < stop) begin
      if (!skip_holes(pg) || pg >= stop) break;
      if (held_low == 0 && pg < LowLimit) begin
        held_low = pg[19:0];
      end else if (pfn_count < StackDepth) begin
        pfn_stack[pfn_count] = pg[63:12];
        pfn_count++;
      end else begin
        return ST_FULL;
      end
      pg += PageBytes;
    end
    return ST_OK;
  endfunction

  // Work out the result of one command and update the shadow state.
  function automatic beat_t allocate_step(stim_t s);
    beat_t r;
    int    lo;
    r.page = '0;
    r.st = ST_OK;
    case (s.cmd)
      CMD_UNSAFE: begin
        if (hole_count < UnsafeSlots) begin
          hole_start[hole_count] = s.a;
          hole_end[hole_count] = s.b;
          hole_count++;
        end else begin
          r.st = ST_UFULL;
        end
      end
      CMD_MAP: r.st = walk_entry(s.a, s.b, s.typ);
      CMD_ALLOC: begin
        if (pfn_count > 0) begin
          pfn_count--;
          r.page = {pfn_stack[pfn_count], 12'h000};
        end else begin
          r.st = ST_EMPTY;
        end
      end
      CMD_FREE: begin
        if (pfn_count < StackDepth) begin
          pfn_stack[pfn_count] = s.a[63:12];
          pfn_count++;
        end else begin
          r.st = ST_FULL;
        end
      end
      CMD_LOWEST: begin
        if (pfn_count > 0) begin
          lo = 0;
          for (int i = 1; i < pfn_count; i++)
            if (pfn_stack[i] < pfn_stack[lo]) lo = i;
          r.page = {pfn_stack[lo], 12'h000};
          for (int i = lo + 1; i < pfn_count; i++) pfn_stack[i-1] = pfn_stack[i];
          pfn_count--;
        end else begin
          r.st = ST_EMPTY;
        end
      end
      default: ;
    endcase
    r.free_cnt = pfn_count[12:0];
    r.low = held_low;
    r.high = top_addr;
    return r;
  endfunction

  function automatic stim_t row(logic [2:0] cmd, logic [63:0] a, logic [63:0] b,
                                logic [31:0] typ);
    stim_t s;
    s.cmd = cmd;
    s.a = a;
    s.b = b;
    s.typ = typ;
    s.typed = 1'b0;
    s.want = '{default: '0};
    return s;
  endfunction

  // Row whose result is plain from the state right after reset.
  function automatic stim_t fixed_row(logic [2:0] cmd, logic [63:0] a, logic [63:0] b,
                                      status_t st);
    stim_t s;
    s = row(cmd, a, b, 32'd0);
    s.typed = 1'b1;
    s.want.st = st;
    return s;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly allocates, frees and small usable entries in the low 64 MiB, plus noise.
  function automatic stim_t random_item();
    stim_t s;
    int    pick;
    pick = $urandom_range(99);
    s = row(CMD_ALLOC, rand64(), rand64(), $urandom);
    if (pick < 30) begin
      s.cmd = CMD_ALLOC;
    end else if (pick < 45) begin
      s.cmd = CMD_FREE;
      if ($urandom_range(1)) s.a = 64'($urandom_range(0, 63)) << 12 | 64'($urandom_range(4095));
    end else if (pick < 68) begin
      s.cmd = CMD_MAP;
      s.a = 64'($urandom_range(0, 32'h03FF_FFFF));
      s.b = 64'($urandom_range(0, 8 * 4096 + 100));
      s.typ = TypeUsable;
    end else if (pick < 75) begin
      s.cmd = CMD_MAP;
      if (s.typ == TypeUsable) s.typ = 32'd0;
    end else if (pick < 85) begin
      s.cmd = CMD_LOWEST;
    end else if (pick < 90) begin
      s.cmd = CMD_UNSAFE;
      s.a = 64'($urandom_range(0, 32'h03FF_FFFF));
      s.b = s.a + 64'($urandom_range(0, 16 * 4096));
    end else begin
      s.cmd = 3'($urandom_range(CmdSpare5, CmdSpare7));
    end
    return s;
  endfunction

  // Present one beat at a falling edge and hold it until it is taken.
  task automatic send(stim_t s);
    beat_t r;
    while (idle_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= s.cmd;
    in_first_value <= s.a;
    in_second_value <= s.b;
    in_entry_type <= s.typ;
    do @(posedge clk); while (in_stall);
    r = allocate_step(s);
    due_q.push_back(s.typed ? s.want : r);
    @(negedge clk);
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at cycle %0d: got %h, expected %h", field, cycles, got, want);
    errors++;
  endtask

  // Result side stalls at random, except for one quiet window.
  always @(negedge clk)
    out_stall <= !(cycles > 3000 && cycles < 9000) && $urandom_range(99) < 7;

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    beat_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (due_q.size() == 0) begin
        $display("unexpected result beat at cycle %0d", cycles);
        errors++;
      end else begin
        w = due_q.pop_front();
        if (out_page_address !== w.page) report("page_address", out_page_address, w.page);
        if (out_status !== w.st) report("status", 64'(out_status), 64'(w.st));
        if (out_free_pages !== w.free_cnt)
          report("free_pages", 64'(out_free_pages), 64'(w.free_cnt));
        if (out_low_page !== w.low) report("low_page", 64'(out_low_page), 64'(w.low));
        if (out_highest_address !== w.high)
          report("highest_address", out_highest_address, w.high);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("page_frame_stack_allocator_core regression: fail");
      $finish;
    end
  end

  initial begin
    pfn_count = 0;
    hole_count = 0;
    held_low = '0;
    top_addr = '0;

    // Empty stack, spare codes and unsafe loads, then walks through the corner cases.
    plan_q.push_back(fixed_row(CMD_ALLOC, AllOnes, AllOnes, ST_EMPTY));
    plan_q.push_back(fixed_row(CMD_LOWEST, '0, '0, ST_EMPTY));
    plan_q.push_back(fixed_row(CmdSpare5, AllOnes, '0, ST_OK));
    plan_q.push_back(fixed_row(CmdSpare7, '0, AllOnes, ST_OK));
    plan_q.push_back(fixed_row(CMD_UNSAFE, 64'h5000, 64'h7000, ST_OK));
    plan_q.push_back(fixed_row(CMD_UNSAFE, 64'hFFFF_FFFF_0000_0000, AllOnes, ST_OK));
    plan_q.push_back(row(CMD_MAP, '0, 64'h9000, TypeUsable));
    plan_q.push_back(row(CMD_MAP, 64'hFFFF_FFFE_FFFF_E000, 64'h10000, TypeUsable));
    plan_q.push_back(row(CMD_MAP, AllOnes, AllOnes, 32'hFFFF_FFFF));
    plan_q.push_back(row(CMD_MAP, 64'h123, '0, TypeUsable));
    plan_q.push_back(row(CMD_MAP, LastPage, 64'h1000, TypeUsable));
    plan_q.push_back(row(CMD_LOWEST, '0, '0, '0));
    plan_q.push_back(row(CMD_ALLOC, '0, '0, '0));
    plan_q.push_back(row(CMD_FREE, AllOnes, '0, '0));
    plan_q.push_back(row(CMD_FREE, '0, '0, '0));
    plan_q.push_back(row(CMD_FREE, 64'h3FFF, '0, '0));
    plan_q.push_back(row(CMD_LOWEST, '0, '0, '0));
    plan_q.push_back(row(CMD_UNSAFE, '0, '0, '0));
    plan_q.push_back(row(CMD_UNSAFE, AllOnes, AllOnes, '0));
    plan_q.push_back(row(CMD_MAP, 64'h10_0000, 64'h3000, 32'd2));
    plan_q.push_back(row(CMD_MAP, 64'hF_E001, 64'h4000, TypeUsable));
    plan_q.push_back(row(CMD_ALLOC, '0, '0, '0));
    plan_q.push_back(row(CMD_LOWEST, '0, '0, '0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan_q[i]) send(plan_q[i]);

    // Hold off until the block has drained.
    in_valid <= 1'b0;
    while (due_q.size() != 0) @(negedge clk);

    for (int n = 0; n < 500; n++) begin
      idle_on = !(n >= 150 && n < 300);
      send(random_item());
    end

    // Fill the stack to the brim above the random region, then overflow it.
    idle_on = 1'b1;
    send(row(CMD_MAP, 64'h4000_0000, 64'(4200) * PageBytes, TypeUsable));
    send(row(CMD_FREE, 64'h1234_5000, '0, '0));
    send(row(CMD_LOWEST, '0, '0, '0));
    send(row(CMD_ALLOC, '0, '0, '0));
    send(row(CMD_FREE, 64'h8000, '0, '0));

    in_valid <= 1'b0;
    while (due_q.size() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("page_frame_stack_allocator_core regression: pass");
    end else begin
      $display("page_frame_stack_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
